// ----- design/float_exp2_polynomial_core_macros.svh -----
// ----------------------------------------------------------------------------
// float_exp2_polynomial_core_macros
// assertion macros used by the checker file
// ----------------------------------------------------------------------------
`ifndef FLOAT_EXP2_POLYNOMIAL_CORE_MACROS_SVH
`define FLOAT_EXP2_POLYNOMIAL_CORE_MACROS_SVH

// same-cycle implication
`define FE2P_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define FE2P_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- design/fe2p_pkg.sv -----
// ----------------------------------------------------------------------------
// fe2p_pkg
// shared types, constants and coefficient table of the exp2 core
// ----------------------------------------------------------------------------
package fe2p_pkg;

  localparam int MANT_BITS = 23;
  localparam int COEF_Q    = 28;
  localparam int COEF_W    = COEF_Q + 1;
  localparam int ACC_W     = COEF_Q + 2;
  localparam int FLOOR_W   = 10;
  localparam int EXP_W     = 11;
  localparam int ROWS      = 4;
  localparam int TERMS     = 6;

  localparam logic [2:0]  DEG_MIN   = 3'd2;
  localparam logic [2:0]  DEG_MAX   = 3'd5;
  localparam logic [2:0]  DEG_RESET = 3'd5;

  localparam logic [7:0]  EXP_SPECIAL = 8'hFF;
  localparam logic [7:0]  EXP_BIG     = 8'd135;
  localparam logic [31:0] INF_BITS    = 32'h7F80_0000;
  localparam logic [31:0] ZERO_BITS   = 32'h0000_0000;
  localparam logic [31:0] QUIET_BIT   = 32'h0040_0000;
  localparam logic signed [EXP_W-1:0] EXP_BIAS = 11'sd127;
  localparam logic signed [EXP_W-1:0] EXP_TOP  = 11'sd255;
  localparam logic signed [EXP_W-1:0] EXP_ZERO = 11'sd0;

  typedef enum logic [1:0] {
    ST_NORMAL = 2'd0,
    ST_OVF    = 2'd1,
    ST_UNF    = 2'd2,
    ST_NAN    = 2'd3
  } status_t;

  // sideband that travels with each item
  typedef struct packed {
    logic                is_special;
    status_t             status;
    logic [31:0]         special_bits;
    logic [FLOOR_W-1:0]  floor_int;
    logic [1:0]          row;
  } side_t;

  localparam logic [63:0] POW5_15 = 64'd30517578125;

  // round(c * 2^28) from c * 10^15
  function automatic logic [COEF_W-1:0] coef_q28(input logic [63:0] dec);
    logic [63:0] q;
    q = (dec * 64'd8192 + POW5_15 / 64'd2) / POW5_15;
    return q[COEF_W-1:0];
  endfunction

  localparam logic [COEF_W-1:0] CZ = '0;

  // one row per degree, leading zeros pad the lower degrees
  localparam logic [COEF_W-1:0] COEF_TAB [ROWS][TERMS] = '{
    '{CZ, CZ, CZ,
      coef_q28(64'd342656060127262), coef_q28(64'd649426903806752),
      coef_q28(64'd1003762902276502)},
    '{CZ, CZ,
      coef_q28(64'd79019886937600), coef_q28(64'd224126229720834),
      coef_q28(64'd696838835969343), coef_q28(64'd999811907929616)},
    '{CZ,
      coef_q28(64'd13676523800069), coef_q28(64'd51666839337489),
      coef_q28(64'd241710331749456), coef_q28(64'd692931257740765),
      coef_q28(64'd1000007286841045)},
    '{coef_q28(64'd1894376824293), coef_q28(64'd8940581738581),
      coef_q28(64'd55876565615224), coef_q28(64'd240131684394877),
      coef_q28(64'd693156778791506), coef_q28(64'd999999769472682)}
  };

endpackage

// ----- design/fe2p_split.sv -----
// ----------------------------------------------------------------------------
// fe2p_split
// two stages: align x to fixed point, then floor and fraction
// ----------------------------------------------------------------------------
module fe2p_split #(
  parameter int FRACTION_BITS = 24
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [31:0]               in_x_bits,
  input  logic [1:0]                in_row,
  output logic                      dn_valid,
  input  logic                      dn_stall,
  output logic [fe2p_pkg::ACC_W-1:0] dn_acc,
  output logic [FRACTION_BITS-1:0]  dn_frac,
  output fe2p_pkg::side_t           dn_side
);
  import fe2p_pkg::*;

  localparam int MAG_W = FRACTION_BITS + 8;
  localparam int T_W   = MAG_W + 1;
  localparam logic signed [9:0] SH_BIAS = 10'(FRACTION_BITS - 150);

  logic              s1_valid_r, s2_valid_r;
  logic              s1_hold, s2_hold;
  logic              s1_neg_r, s1_lost_r;
  logic [MAG_W-1:0]  s1_mag_r;
  side_t             s1_side_r, s2_side_r;
  logic [ACC_W-1:0]  s2_acc_r;
  logic [FRACTION_BITS-1:0] s2_frac_r;

  logic [7:0]        ef, ee, rs;
  logic [22:0]       frac;
  logic [23:0]       m;
  logic signed [9:0] sh;
  logic [4:0]        ls;
  logic [MAG_W-1:0]  mag_nxt;
  logic              lost_nxt;
  side_t             s1_side_nxt, s2_side_nxt;

  logic [T_W-1:0]    t;
  logic [8:0]        q;
  logic [FRACTION_BITS-1:0] r, frac_nxt;
  logic [FLOOR_W-1:0] floor_nxt;

  assign s2_hold  = s2_valid_r && dn_stall;
  assign s1_hold  = s1_valid_r && s2_hold;
  assign in_stall = s1_hold;

  // stage 1: align
  always_comb begin
    ef   = in_x_bits[30:23];
    frac = in_x_bits[22:0];
    m    = {(ef != 8'd0), frac};
    ee   = (ef != 8'd0) ? ef : 8'd1;
    sh   = $signed({2'b00, ee}) + SH_BIAS;
    ls   = sh[4:0];
    rs   = 8'(-sh);
    if (sh >= 10'sd0) begin
      mag_nxt  = MAG_W'(m) << ls;
      lost_nxt = 1'b0;
    end else begin
      mag_nxt  = MAG_W'(m >> rs);
      lost_nxt = |(m & ~(24'hFF_FFFF << rs));
    end

    s1_side_nxt = '0;
    s1_side_nxt.row = in_row;
    s1_side_nxt.status = ST_NORMAL;
    if (ef == EXP_SPECIAL && frac != 23'd0) begin
      s1_side_nxt.is_special   = 1'b1;
      s1_side_nxt.status       = ST_NAN;
      s1_side_nxt.special_bits = in_x_bits | QUIET_BIT;
    end else if (ef >= EXP_BIG) begin
      s1_side_nxt.is_special = 1'b1;
      if (in_x_bits[31]) begin
        s1_side_nxt.status       = ST_UNF;
        s1_side_nxt.special_bits = ZERO_BITS;
      end else begin
        s1_side_nxt.status       = ST_OVF;
        s1_side_nxt.special_bits = INF_BITS;
      end
    end
  end

  // stage 2: floor and fraction
  always_comb begin
    t = {1'b0, s1_mag_r} + T_W'(s1_lost_r);
    q = t[T_W-1:FRACTION_BITS];
    r = t[FRACTION_BITS-1:0];
    if (!s1_neg_r) begin
      floor_nxt = FLOOR_W'(s1_mag_r[MAG_W-1:FRACTION_BITS]);
      frac_nxt  = s1_mag_r[FRACTION_BITS-1:0];
    end else if (r == '0) begin
      floor_nxt = FLOOR_W'(0) - FLOOR_W'(q);
      frac_nxt  = '0;
    end else begin
      floor_nxt = FLOOR_W'(0) - FLOOR_W'(q) - FLOOR_W'(1);
      frac_nxt  = ~r + FRACTION_BITS'(1);
    end
    s2_side_nxt = s1_side_r;
    s2_side_nxt.floor_int = floor_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
    end else begin
      if (!s1_hold) s1_valid_r <= in_valid;
      if (!s2_hold) s2_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!s1_hold) begin
      s1_neg_r  <= in_x_bits[31];
      s1_lost_r <= lost_nxt;
      s1_mag_r  <= mag_nxt;
      s1_side_r <= s1_side_nxt;
    end
    if (!s2_hold) begin
      s2_acc_r  <= ACC_W'(COEF_TAB[s1_side_r.row][0]);
      s2_frac_r <= frac_nxt;
      s2_side_r <= s2_side_nxt;
    end
  end

  assign dn_valid = s2_valid_r;
  assign dn_acc   = s2_acc_r;
  assign dn_frac  = s2_frac_r;
  assign dn_side  = s2_side_r;

endmodule

// ----- design/fe2p_horner_stage.sv -----
// ----------------------------------------------------------------------------
// fe2p_horner_stage
// one registered horner step: acc = ((acc * f) >> fraction bits) + coef
// ----------------------------------------------------------------------------
module fe2p_horner_stage #(
  parameter int FRACTION_BITS = 24,
  parameter int STAGE         = 1
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       up_valid,
  output logic                       up_stall,
  input  logic [fe2p_pkg::ACC_W-1:0] up_acc,
  input  logic [FRACTION_BITS-1:0]   up_frac,
  input  fe2p_pkg::side_t            up_side,
  output logic                       dn_valid,
  input  logic                       dn_stall,
  output logic [fe2p_pkg::ACC_W-1:0] dn_acc,
  output logic [FRACTION_BITS-1:0]   dn_frac,
  output fe2p_pkg::side_t            dn_side
);
  import fe2p_pkg::*;

  localparam int PROD_W = ACC_W + FRACTION_BITS;

  logic              valid_r;
  logic [ACC_W-1:0]  acc_r, acc_nxt;
  logic [FRACTION_BITS-1:0] frac_r;
  side_t             side_r;
  logic [PROD_W-1:0] prod;

  assign up_stall = valid_r && dn_stall;

  always_comb begin
    prod    = PROD_W'(up_acc) * PROD_W'(up_frac);
    acc_nxt = ACC_W'(prod >> FRACTION_BITS) + ACC_W'(COEF_TAB[up_side.row][STAGE]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (!up_stall) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!up_stall) begin
      acc_r  <= acc_nxt;
      frac_r <= up_frac;
      side_r <= up_side;
    end
  end

  assign dn_valid = valid_r;
  assign dn_acc   = acc_r;
  assign dn_frac  = frac_r;
  assign dn_side  = side_r;

endmodule

// ----- design/fe2p_pack.sv -----
// ----------------------------------------------------------------------------
// fe2p_pack
// normalize the polynomial value, build the exponent, range check, output reg
// ----------------------------------------------------------------------------
module fe2p_pack (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       up_valid,
  output logic                       up_stall,
  input  logic [fe2p_pkg::ACC_W-1:0] up_acc,
  input  fe2p_pkg::side_t            up_side,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [31:0]                out_result_bits,
  output logic [1:0]                 out_range_status
);
  import fe2p_pkg::*;

  logic                    valid_r;
  logic [31:0]             bits_r, bits_nxt;
  status_t                 status_r, status_nxt;
  logic signed [EXP_W-1:0] e_base, e_out;
  logic [MANT_BITS-1:0]    mant;

  assign up_stall = valid_r && out_stall;

  always_comb begin
    e_base = EXP_W'($signed(up_side.floor_int)) + EXP_BIAS;
    if (up_acc[COEF_Q+1]) begin
      e_out = e_base + 11'sd1;
      mant  = up_acc[COEF_Q -: MANT_BITS];
    end else if (up_acc[COEF_Q]) begin
      e_out = e_base;
      mant  = up_acc[COEF_Q-1 -: MANT_BITS];
    end else begin
      e_out = e_base - 11'sd1;
      mant  = up_acc[COEF_Q-2 -: MANT_BITS];
    end

    if (up_side.is_special) begin
      bits_nxt   = up_side.special_bits;
      status_nxt = up_side.status;
    end else if (e_out >= EXP_TOP) begin
      bits_nxt   = INF_BITS;
      status_nxt = ST_OVF;
    end else if (e_out <= EXP_ZERO) begin
      bits_nxt   = ZERO_BITS;
      status_nxt = ST_UNF;
    end else begin
      bits_nxt   = {1'b0, e_out[7:0], mant};
      status_nxt = ST_NORMAL;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (!up_stall) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!up_stall) begin
      bits_r   <= bits_nxt;
      status_r <= status_nxt;
    end
  end

  assign out_valid        = valid_r;
  assign out_result_bits  = bits_r;
  assign out_range_status = status_r;

endmodule

// ----- design/float_exp2_polynomial_core.sv -----
// ----------------------------------------------------------------------------
// float_exp2_polynomial_core: single-precision 2^x by exponent bits and polynomial
// pipeline stages from input transfer to result: align, floor, 5 horner, pack
// one item per cycle unless stalled; each horner multiply-add has its own stage
// synchronous active-low reset empties the pipeline and sets the degree to 5
// ----------------------------------------------------------------------------
module float_exp2_polynomial_core #(
  parameter int FRACTION_BITS = 24
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [2:0]  cfg_wr_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] in_x_bits,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_result_bits,
  output logic [1:0]  out_range_status
);
  import fe2p_pkg::*;

  localparam int NSTG = TERMS - 1;

  logic [2:0]  poly_degree_r;
  logic [1:0]  row;

  logic                     valid_c [NSTG+1];
  logic                     stall_c [NSTG+1];
  logic [ACC_W-1:0]         acc_c   [NSTG+1];
  logic [FRACTION_BITS-1:0] frac_c  [NSTG+1];
  side_t                    side_c  [NSTG+1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      poly_degree_r <= DEG_RESET;
    end else if (cfg_wr_en) begin
      poly_degree_r <= cfg_wr_data;
    end
  end

  always_comb begin
    if (poly_degree_r inside {[DEG_MIN:DEG_MAX]}) begin
      row = 2'(poly_degree_r - DEG_MIN);
    end else if (poly_degree_r < DEG_MIN) begin
      row = '0;
    end else begin
      row = 2'(DEG_MAX - DEG_MIN);
    end
  end

  fe2p_split #(.FRACTION_BITS(FRACTION_BITS)) u_split (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_x_bits(in_x_bits),
    .in_row   (row),
    .dn_valid (valid_c[0]),
    .dn_stall (stall_c[0]),
    .dn_acc   (acc_c[0]),
    .dn_frac  (frac_c[0]),
    .dn_side  (side_c[0])
  );

  for (genvar g = 1; g <= NSTG; g++) begin : g_horner
    fe2p_horner_stage #(.FRACTION_BITS(FRACTION_BITS), .STAGE(g)) u_stage (
      .clk     (clk),
      .rst_n   (rst_n),
      .up_valid(valid_c[g-1]),
      .up_stall(stall_c[g-1]),
      .up_acc  (acc_c[g-1]),
      .up_frac (frac_c[g-1]),
      .up_side (side_c[g-1]),
      .dn_valid(valid_c[g]),
      .dn_stall(stall_c[g]),
      .dn_acc  (acc_c[g]),
      .dn_frac (frac_c[g]),
      .dn_side (side_c[g])
    );
  end

  fe2p_pack u_pack (
    .clk             (clk),
    .rst_n           (rst_n),
    .up_valid        (valid_c[NSTG]),
    .up_stall        (stall_c[NSTG]),
    .up_acc          (acc_c[NSTG]),
    .up_side         (side_c[NSTG]),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_result_bits (out_result_bits),
    .out_range_status(out_range_status)
  );

endmodule

// ----- design/fe2p_checker.sv -----
// ----------------------------------------------------------------------------
// fe2p_checker
// port-level checks of the exp2 core, bound to the top level
// ----------------------------------------------------------------------------
`include "float_exp2_polynomial_core_macros.svh"

module fe2p_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [31:0] out_result_bits,
  input logic [1:0]  out_range_status
);
  import fe2p_pkg::*;

  `FE2P_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_result_bits) && $stable(out_range_status), "stalled result changed")

  `FE2P_ASSERT_NOW(a_in_stall_cause, clk, rst_n, in_stall, out_valid && out_stall, "input stalled while result side is free")

  `FE2P_ASSERT_NOW(a_normal_exp, clk, rst_n, out_valid && out_range_status == ST_NORMAL, out_result_bits[30:23] != 8'h00 && out_result_bits[30:23] != EXP_SPECIAL && !out_result_bits[31], "normal result with bad exponent")

  `FE2P_ASSERT_NOW(a_ovf_inf, clk, rst_n, out_valid && out_range_status == ST_OVF, out_result_bits == INF_BITS, "overflow result is not infinity")

  `FE2P_ASSERT_NOW(a_nan_quiet, clk, rst_n, out_valid && out_range_status == ST_NAN, out_result_bits[30:23] == EXP_SPECIAL && out_result_bits[22], "nan result is not a quiet nan")

endmodule

bind float_exp2_polynomial_core fe2p_checker u_fe2p_checker (.*);

// ----- test/testbench.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: exp2 polynomial core
// drives single-precision arguments through the core under every degree
// setting, predicts the 2^x result of each untyped argument with an independent
// fixed-point model and compares result bits and range status in order, under
// random valid gaps, output stalls and one long output hold-off
// ----------------------------------------------------------------------------
module testbench;
  import fe2p_pkg::*;

  localparam int          FRAC_W          = 24;
  localparam logic [63:0] FRAC_ONE        = 64'd1 << FRAC_W;
  localparam logic [63:0] FRAC_MASK       = FRAC_ONE - 64'd1;
  localparam int          COEF_FRAC       = 28;
  localparam int          MANT_W          = 23;
  localparam int          EXP_OFFSET      = 127;
  localparam logic [63:0] FIVE_POW_15     = 64'd30517578125;
  localparam logic [2:0]  DEGREE_AT_RESET = 3'd5;
  localparam int          DIRECTED_ROWS   = 25;
  localparam int          RANDOM_PHASES   = 8;
  localparam int          ITEMS_PER_PHASE = 116;
  localparam int          HOLD_CYCLES     = 80;
  localparam int          DRAIN_CYCLES    = 16;
  localparam int          WATCHDOG_LIMIT  = 2000;

  typedef struct {
    logic [31:0] x;
    logic [31:0] bits;
    status_t     status;
  } exp2_result_t;

  typedef struct packed {
    logic [31:0] x;
    logic        typed;
    logic [31:0] bits;
    status_t     status;
  } stim_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_wr_en = 1'b0;
  logic [2:0]  cfg_wr_data = 3'd0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [31:0] in_x_bits = 32'h0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [31:0] out_result_bits;
  logic [1:0]  out_range_status;

  exp2_result_t pending_powers[$];
  logic [2:0]   degree_now = DEGREE_AT_RESET;
  int           gap_pct = 0;
  int           stall_pct = 0;
  bit           hold_request = 1'b0;
  int           mismatches = 0;
  int           arguments_sent = 0;
  int           results_checked = 0;
  int           status_seen [4];

  float_exp2_polynomial_core #(
    .FRACTION_BITS(FRAC_W)
  ) uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_x_bits        (in_x_bits),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_result_bits  (out_result_bits),
    .out_range_status (out_range_status)
  );

  always #10 clk = ~clk;

  // coefficients in units of 1e-15, highest power first, scaled to q28
  function automatic logic [63:0] coef_q28_of(input int row, input int term);
    logic [63:0] e15;
    case (row * 8 + term)
      0:  e15 = 64'd342656060127262;
      1:  e15 = 64'd649426903806752;
      2:  e15 = 64'd1003762902276502;
      8:  e15 = 64'd79019886937600;
      9:  e15 = 64'd224126229720834;
      10: e15 = 64'd696838835969343;
      11: e15 = 64'd999811907929616;
      16: e15 = 64'd13676523800069;
      17: e15 = 64'd51666839337489;
      18: e15 = 64'd241710331749456;
      19: e15 = 64'd692931257740765;
      20: e15 = 64'd1000007286841045;
      24: e15 = 64'd1894376824293;
      25: e15 = 64'd8940581738581;
      26: e15 = 64'd55876565615224;
      27: e15 = 64'd240131684394877;
      28: e15 = 64'd693156778791506;
      29: e15 = 64'd999999769472682;
      default: e15 = 64'd0;
    endcase
    return (e15 * 64'd8192 + FIVE_POW_15 / 64'd2) / FIVE_POW_15;
  endfunction

  function automatic void predict_exp2(input logic [31:0] x, input logic [2:0] degree,
                                       output logic [31:0] bits, output status_t status);
    logic        neg;
    logic        lost;
    logic [7:0]  ef;
    logic [7:0]  e8;
    logic [63:0] m;
    logic [63:0] mag;
    logic [63:0] t;
    logic [63:0] r;
    logic [63:0] f;
    logic [63:0] acc;
    logic [63:0] mant;
    longint      i;
    longint      e_out;
    int          ee;
    int          shift;
    int          row;
    int          k;
    neg  = x[31];
    ef   = x[30:23];
    lost = 1'b0;
    if (ef == 8'hFF && x[22:0] != 23'd0) begin
      bits   = x | QUIET_BIT;
      status = ST_NAN;
    end else if (ef >= 8'd135) begin
      bits   = neg ? ZERO_BITS : INF_BITS;
      status = neg ? ST_UNF : ST_OVF;
    end else begin
      m     = (ef != 8'd0) ? {40'd0, 1'b1, x[22:0]} : {41'd0, x[22:0]};
      ee    = (ef != 8'd0) ? int'(ef) : 1;
      shift = ee - 150 + FRAC_W;
      if (shift >= 0) begin
        mag = m << shift;
      end else if (-shift >= 64) begin
        mag  = 64'd0;
        lost = (m != 64'd0);
      end else begin
        mag  = m >> (-shift);
        lost = ((m & ((64'd1 << (-shift)) - 64'd1)) != 64'd0);
      end
      if (!neg) begin
        i = longint'(mag >> FRAC_W);
        f = mag & FRAC_MASK;
      end else begin
        t = mag + {63'd0, lost};
        r = t & FRAC_MASK;
        i = -longint'(t >> FRAC_W);
        if (r == 64'd0) begin
          f = 64'd0;
        end else begin
          i = i - 1;
          f = FRAC_ONE - r;
        end
      end
      row = (degree < 3'd2) ? 0 : (degree > 3'd5) ? 3 : int'(degree) - 2;
      acc = coef_q28_of(row, 0);
      for (k = 1; k <= row + 2; k++) begin
        acc = ((acc * f) >> FRAC_W) + coef_q28_of(row, k);
      end
      e_out = i + EXP_OFFSET;
      if (acc >= (64'd1 << (COEF_FRAC + 1))) begin
        e_out = e_out + 1;
        mant  = (acc - (64'd1 << (COEF_FRAC + 1))) >> (COEF_FRAC + 1 - MANT_W);
      end else if (acc >= (64'd1 << COEF_FRAC)) begin
        mant = (acc - (64'd1 << COEF_FRAC)) >> (COEF_FRAC - MANT_W);
      end else begin
        e_out = e_out - 1;
        mant  = ((acc << 1) & ((64'd1 << COEF_FRAC) - 64'd1)) >> (COEF_FRAC - MANT_W);
      end
      if (e_out >= 255) begin
        bits   = INF_BITS;
        status = ST_OVF;
      end else if (e_out <= 0) begin
        bits   = ZERO_BITS;
        status = ST_UNF;
      end else begin
        e8     = e_out[7:0];
        bits   = {1'b0, e8, mant[MANT_W-1:0]};
        status = ST_NORMAL;
      end
    end
  endfunction

  // directed arguments at the reset degree; typed rows are read off directly
  function automatic stim_row_t directed_row(input int idx);
    stim_row_t s;
    case (idx)
      0:  s = '{32'h0000_0000, 1'b0, ZERO_BITS, ST_NORMAL};
      1:  s = '{32'h8000_0000, 1'b0, ZERO_BITS, ST_NORMAL};
      2:  s = '{32'h0000_0001, 1'b0, ZERO_BITS, ST_NORMAL};
      3:  s = '{32'h8000_0001, 1'b0, ZERO_BITS, ST_NORMAL};
      4:  s = '{32'h807F_FFFF, 1'b0, ZERO_BITS, ST_NORMAL};
      5:  s = '{32'h3F80_0000, 1'b0, ZERO_BITS, ST_NORMAL};
      6:  s = '{32'hBF80_0000, 1'b0, ZERO_BITS, ST_NORMAL};
      7:  s = '{32'h3F7F_FFFF, 1'b0, ZERO_BITS, ST_NORMAL};
      8:  s = '{32'hBF7F_FFFF, 1'b0, ZERO_BITS, ST_NORMAL};
      9:  s = '{32'h42FE_0000, 1'b0, ZERO_BITS, ST_NORMAL};
      10: s = '{32'h4300_0000, 1'b0, ZERO_BITS, ST_NORMAL};
      11: s = '{32'hC2FC_0000, 1'b0, ZERO_BITS, ST_NORMAL};
      12: s = '{32'hC301_0000, 1'b1, ZERO_BITS, ST_UNF};
      13: s = '{32'h437F_FFFF, 1'b1, INF_BITS, ST_OVF};
      14: s = '{32'hC37F_FFFF, 1'b1, ZERO_BITS, ST_UNF};
      15: s = '{32'h4380_0000, 1'b1, INF_BITS, ST_OVF};
      16: s = '{32'hC380_0000, 1'b1, ZERO_BITS, ST_UNF};
      17: s = '{32'h7F7F_FFFF, 1'b1, INF_BITS, ST_OVF};
      18: s = '{32'hFF7F_FFFF, 1'b1, ZERO_BITS, ST_UNF};
      19: s = '{32'h7F80_0000, 1'b1, INF_BITS, ST_OVF};
      20: s = '{32'hFF80_0000, 1'b1, ZERO_BITS, ST_UNF};
      21: s = '{32'h7F80_0001, 1'b1, 32'h7FC0_0001, ST_NAN};
      22: s = '{32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF, ST_NAN};
      23: s = '{32'hFFBF_FFFF, 1'b1, 32'hFFFF_FFFF, ST_NAN};
      default: s = '{32'h7FC0_0000, 1'b1, 32'h7FC0_0000, ST_NAN};
    endcase
    return s;
  endfunction

  // mostly finite arguments below 256 in magnitude, plus saturation, specials and noise
  function automatic logic [31:0] random_argument();
    logic [31:0] r;
    logic [22:0] mant;
    logic        sign;
    int          pick;
    int          e;
    r    = $urandom();
    mant = r[22:0];
    sign = r[31];
    pick = $urandom_range(99);
    if (pick < 50) begin
      e = $urandom_range(134, 100);
    end else if (pick < 62) begin
      e    = $urandom_range(134, 120);
      mant = mant & ~((23'd1 << $urandom_range(23)) - 23'd1);
    end else if (pick < 72) begin
      e = $urandom_range(254, 135);
    end else if (pick < 82) begin
      e = 0;
      if ($urandom_range(3) == 0) mant = 23'd0;
    end else if (pick < 87) begin
      e = 255;
      if ($urandom_range(1) == 0) mant = 23'd0;
    end else begin
      return $urandom();
    end
    return {sign, e[7:0], mant};
  endfunction

  task automatic send_argument(input logic [31:0] x, input logic typed,
                               input logic [31:0] typed_bits, input status_t typed_status);
    exp2_result_t want;
    @(negedge clk);
    while ($urandom_range(99) < gap_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid  <= 1'b1;
    in_x_bits <= x;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    want.x = x;
    if (typed) begin
      want.bits   = typed_bits;
      want.status = typed_status;
    end else begin
      predict_exp2(x, degree_now, want.bits, want.status);
    end
    pending_powers.push_back(want);
    arguments_sent++;
  endtask

  task automatic drain_pipeline();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_powers.size() != 0) @(posedge clk);
  endtask

  task automatic write_degree(input logic [2:0] degree);
    @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= degree;
    @(negedge clk);
    cfg_wr_en  <= 1'b0;
    degree_now = degree;
  endtask

  // receiver: random stalls, plus one long hold-off on request
  initial begin
    int hold_left;
    bit hold_done;
    hold_left = 0;
    hold_done = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else if (hold_request && !hold_done) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(99) < stall_pct);
      end
    end
  end

  always @(posedge clk) begin : check_result
    exp2_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      status_seen[out_range_status]++;
      if (pending_powers.size() == 0) begin
        if (mismatches < 10)
          $display("unexpected result %h status %0d with nothing pending",
                   out_result_bits, out_range_status);
        mismatches++;
      end else begin
        want = pending_powers.pop_front();
        results_checked++;
        if (out_result_bits !== want.bits || out_range_status !== want.status) begin
          if (mismatches < 10)
            $display("mismatch x=%h deg=%0d: expected %h status %0d, got %h status %0d",
                     want.x, degree_now, want.bits, want.status,
                     out_result_bits, out_range_status);
          mismatches++;
        end
      end
    end
  end

  initial begin : watchdog
    int quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall))
        quiet_cycles = 0;
      else
        quiet_cycles++;
    end
    $display("timeout: no transfer for %0d cycles, %0d results outstanding",
             WATCHDOG_LIMIT, pending_powers.size());
    $display("CHECK FAILED");
    $finish;
  end

  initial begin : stimulus
    stim_row_t   row;
    logic [2:0]  degree;
    int          p;
    int          n;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // reset degree, no idling
    for (n = 0; n < DIRECTED_ROWS; n++) begin
      row = directed_row(n);
      send_argument(row.x, row.typed, row.bits, row.status);
    end
    drain_pipeline();

    for (p = 0; p < RANDOM_PHASES; p++) begin
      case (p)
        0: begin degree = 3'd2; gap_pct = 0;  stall_pct = 0;  end
        1: begin degree = 3'd3; gap_pct = 64; stall_pct = 0;  end
        2: begin degree = 3'd4; gap_pct = 0;  stall_pct = 64; end
        3: begin degree = 3'd5; gap_pct = 20; stall_pct = 20; end
        4: begin degree = 3'd0; gap_pct = 0;  stall_pct = 0;  end
        5: begin degree = 3'd7; gap_pct = 64; stall_pct = 0;  end
        6: begin degree = 3'd1; gap_pct = 0;  stall_pct = 64; end
        default: begin degree = 3'd6; gap_pct = 20; stall_pct = 20; end
      endcase
      write_degree(degree);
      for (n = 0; n < ITEMS_PER_PHASE; n++) begin
        if (p == 0 && n == 30) hold_request = 1'b1;
        send_argument(random_argument(), 1'b0, ZERO_BITS, ST_NORMAL);
      end
      drain_pipeline();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("covered %0d arguments over all eight degree codes, %0d results compared",
             arguments_sent, results_checked);
    $display("status mix: %0d normal, %0d overflow, %0d underflow, %0d nan; %0d mismatches",
             status_seen[0], status_seen[1], status_seen[2], status_seen[3], mismatches);
    if (mismatches == 0 && pending_powers.size() == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+design
design/fe2p_pkg.sv
design/fe2p_split.sv
design/fe2p_horner_stage.sv
design/fe2p_pack.sv
design/float_exp2_polynomial_core.sv
design/fe2p_checker.sv
test/testbench.sv
